@@ rtl/hanu_pkg.sv @@
// ----------------------------------------------------------------------------
// hanu_pkg: shared types and constants for the Hopfield node update unit
// Sizes of the node grid, field widths and the structs that pass between
// the evaluation logic and the node state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hanu_pkg;

   // Grid geometry
   localparam int SIDE   = 4;
   localparam int NODES  = SIDE * SIDE;
   localparam int NODE_W = $clog2(NODES);
   // Largest count of set neighbors: rest of the row plus rest of the column
   localparam int CNT_W  = $clog2(2 * SIDE - 1);

   // Field widths
   localparam int IDX_W  = 2;
   localparam int COST_W = 16;
   localparam int ACT_W  = 23;
   localparam int TOT_W  = 24;

   // Word widths on the streaming ports
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // Largest cost after reset: minus 100 in Q11.4
   localparam logic signed [COST_W-1:0] LARGEST_RESET = -16'sd1600;

   // Operation codes carried on req_tuser
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   // One input word after unpacking
   typedef struct packed {
      op_type                    operation;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          column;
      logic signed [COST_W-1:0]  cost;
      logic                      initial_state;
   } item_type;

   // One result word before packing
   typedef struct packed {
      logic                      previous_state;
      logic                      node_state;
      logic signed [ACT_W-1:0]   activation;
      logic signed [TOT_W-1:0]   total_cost;
   } result_type;

   // State write from the evaluation logic
   typedef struct packed {
      logic                      node_en;
      logic [NODE_W-1:0]         node_idx;
      logic                      node_bit;
      logic                      cost_en;
      logic signed [COST_W-1:0]  cost;
      logic                      largest_en;
      logic signed [TOT_W-1:0]   total;
   } update_type;

endpackage

`default_nettype wire

@@ rtl/hopfield_assignment_node_update_unit.sv @@
// ----------------------------------------------------------------------------
// hopfield_assignment_node_update_unit: Hopfield assignment node update
// Loads node costs and bits, updates single nodes named by the caller and
// reports the new node bit, its activation and the total cost of set nodes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  req_    | in  | row, column, cost, initial_state (24b) | operation
//  rsp_    | out | prev, node, activation, total (56b)    | -
//
//  One word per cycle sustained while results are taken; an accepted word
//  passes the input register, then evaluation into the result register.
//  State is read and written in the evaluation cycle, so a word sees all
//  earlier words. Reset clears node bits and total, sets the largest cost
//  to minus 100. A stalled result holds the input register; req_tready
//  stays high while the input register can move on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hopfield_assignment_node_update_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // row[1:0], column[3:2], cost[19:4], initial_state[20], zero pad
   input  wire  [hanu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation[0]
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // previous_state[0], node_state[1], activation[24:2],
   // total_cost[48:25], zero pad
   output logic [hanu_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic                                   in_valid_ff, in_valid_in;
   hanu_pkg::item_type                     in_item_ff;
   logic                                   out_valid_ff, out_valid_in;
   hanu_pkg::result_type                   out_res_ff;
   logic                                   advance;
   logic [hanu_pkg::NODE_W-1:0]            node_idx;
   hanu_pkg::update_type                   upd;
   hanu_pkg::result_type                   result;
   logic signed [hanu_pkg::COST_W-1:0]     stored_cost;
   logic [hanu_pkg::NODES-1:0]             node_bits;
   logic signed [hanu_pkg::COST_W-1:0]     largest;
   logic signed [hanu_pkg::TOT_W-1:0]      total;

   // Flow control
   assign advance      = !out_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.operation     <= hanu_pkg::op_type'(req_tuser);
         in_item_ff.row           <= req_tdata[1:0];
         in_item_ff.column        <= req_tdata[3:2];
         in_item_ff.cost          <= $signed(req_tdata[19:4]);
         in_item_ff.initial_state <= req_tdata[20];
      end
   end

   // Evaluation and state
   hanu_eval u_eval (
      .active      (in_valid_ff && advance),
      .item        (in_item_ff),
      .stored_cost (stored_cost),
      .node_bits   (node_bits),
      .largest     (largest),
      .total       (total),
      .node_idx    (node_idx),
      .upd         (upd),
      .result      (result)
   );

   hanu_state u_state (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .rd_idx    (node_idx),
      .rd_cost   (stored_cost),
      .node_bits (node_bits),
      .largest   (largest),
      .total     (total)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_res_ff.total_cost, out_res_ff.activation,
                        out_res_ff.node_state, out_res_ff.previous_state};

endmodule

`default_nettype wire

@@ rtl/hanu_state.sv @@
// ----------------------------------------------------------------------------
// hanu_state: node state of the network
// Holds the cost store, the node bits, the largest cost loaded and the
// running total of set-node costs. One read port on the cost store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hanu_state (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire hanu_pkg::update_type                  upd,
   input  wire  [hanu_pkg::NODE_W-1:0]                rd_idx,
   output logic signed [hanu_pkg::COST_W-1:0]         rd_cost,
   output logic [hanu_pkg::NODES-1:0]                 node_bits,
   output logic signed [hanu_pkg::COST_W-1:0]         largest,
   output logic signed [hanu_pkg::TOT_W-1:0]          total
);

   logic [hanu_pkg::COST_W-1:0]         cost_ff [hanu_pkg::NODES];
   logic [hanu_pkg::NODES-1:0]          node_bits_ff;
   logic signed [hanu_pkg::COST_W-1:0]  largest_ff;
   logic signed [hanu_pkg::TOT_W-1:0]   total_ff;

   // Cost store, no reset: entries are defined once loaded
   always_ff @(posedge clock) begin
      if (upd.cost_en) begin
         cost_ff[upd.node_idx] <= upd.cost;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         node_bits_ff <= '0;
         largest_ff   <= hanu_pkg::LARGEST_RESET;
         total_ff     <= '0;
      end else begin
         if (upd.node_en) begin
            node_bits_ff[upd.node_idx] <= upd.node_bit;
            total_ff                   <= upd.total;
         end
         if (upd.largest_en) begin
            largest_ff <= upd.cost;
         end
      end
   end

   assign rd_cost   = $signed(cost_ff[rd_idx]);
   assign node_bits = node_bits_ff;
   assign largest   = largest_ff;
   assign total     = total_ff;

endmodule

`default_nettype wire

@@ rtl/hanu_eval.sv @@
// ----------------------------------------------------------------------------
// hanu_eval: node evaluation
// Works out one item against the current state: load bookkeeping or the
// activation of the named node, the new node bit and the new total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hanu_eval (
   input  wire                                 active,
   input  wire hanu_pkg::item_type             item,
   input  wire  signed [hanu_pkg::COST_W-1:0]  stored_cost,
   input  wire  [hanu_pkg::NODES-1:0]          node_bits,
   input  wire  signed [hanu_pkg::COST_W-1:0]  largest,
   input  wire  signed [hanu_pkg::TOT_W-1:0]   total,
   output logic [hanu_pkg::NODE_W-1:0]         node_idx,
   output hanu_pkg::update_type                upd,
   output hanu_pkg::result_type                result
);

   logic                                 in_range;
   logic                                 is_load;
   logic                                 prev_bit;
   logic                                 new_bit;
   logic [hanu_pkg::CNT_W-1:0]           set_count;
   logic signed [hanu_pkg::COST_W:0]     twice_largest;
   logic signed [hanu_pkg::COST_W+hanu_pkg::CNT_W+1:0] penalty;
   logic signed [hanu_pkg::ACT_W-1:0]    act;
   logic signed [hanu_pkg::COST_W-1:0]   add_cost;
   logic signed [hanu_pkg::COST_W-1:0]   sub_cost;
   logic signed [hanu_pkg::TOT_W-1:0]    new_total;

   // Address of the named node
   assign in_range = (int'(item.row) < hanu_pkg::SIDE) && (int'(item.column) < hanu_pkg::SIDE);
   assign node_idx = hanu_pkg::NODE_W'(int'(item.row) * hanu_pkg::SIDE + int'(item.column));
   assign is_load  = (item.operation == hanu_pkg::OP_LOAD);
   assign prev_bit = node_bits[node_idx];

   // Set nodes elsewhere in the row and in the column
   always_comb begin
      set_count = '0;
      for (int k = 0; k < hanu_pkg::SIDE; k++) begin
         if (k != int'(item.row)) begin
            set_count = set_count + hanu_pkg::CNT_W'(
               node_bits[hanu_pkg::NODE_W'(k * hanu_pkg::SIDE + int'(item.column))]);
         end
         if (k != int'(item.column)) begin
            set_count = set_count + hanu_pkg::CNT_W'(
               node_bits[hanu_pkg::NODE_W'(int'(item.row) * hanu_pkg::SIDE + k)]);
         end
      end
   end

   // Activation: 2L - cost - 2L*n
   assign twice_largest = {largest, 1'b0};
   assign penalty       = twice_largest * $signed({1'b0, set_count});
   assign act           = hanu_pkg::ACT_W'(twice_largest) - hanu_pkg::ACT_W'(stored_cost)
                          - hanu_pkg::ACT_W'(penalty);

   // New node bit and running total
   assign new_bit  = is_load ? item.initial_state : ~act[hanu_pkg::ACT_W-1];
   assign add_cost = (new_bit && (is_load || !prev_bit))
                     ? (is_load ? item.cost : stored_cost) : '0;
   assign sub_cost = (prev_bit && (is_load || !new_bit)) ? stored_cost : '0;
   assign new_total = total + hanu_pkg::TOT_W'(add_cost) - hanu_pkg::TOT_W'(sub_cost);

   // State writes
   always_comb begin
      upd            = '0;
      upd.node_idx   = node_idx;
      upd.node_bit   = new_bit;
      upd.cost       = item.cost;
      upd.total      = new_total;
      if (active && in_range) begin
         upd.node_en    = 1'b1;
         upd.cost_en    = is_load;
         upd.largest_en = is_load && (item.cost > largest);
      end
   end

   // Result word
   always_comb begin
      result            = '0;
      result.total_cost = total;
      if (in_range) begin
         result.previous_state = prev_bit;
         result.node_state     = new_bit;
         result.activation     = is_load ? '0 : act;
         result.total_cost     = new_total;
      end
   end

endmodule

`default_nettype wire

@@ rtl/hanu_checker.sv @@
// ----------------------------------------------------------------------------
// hanu_checker: port checks for the node update unit
// Watches the result channel for reset behavior, stall hold and the
// relation between activation sign and node bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hanu_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [hanu_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Negative activation leaves the node clear
   a_neg_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> !rsp_tdata[1])
      else $error("node set with negative activation");

   // Positive activation (update only) sets the node
   a_pos_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] && (rsp_tdata[24:2] != '0) |-> rsp_tdata[1])
      else $error("node clear with positive activation");

endmodule

bind hopfield_assignment_node_update_unit hanu_checker u_hanu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hopfield_assignment_node_update_unit
// Drives load and update words on the request stream. A scoreboard keeps its
// own copy of the node costs, node bits, largest cost and total cost, works
// out the result of each accepted word and checks the result stream field by
// field. The run covers a directed opening and then random words under four
// idling phases, with a long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import hanu_pkg::*;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving
   localparam int PHASE_WORDS   = 135;
   localparam int HOLD_CYCLES   = 80;
   localparam int TAIL_CYCLES   = 8;
   localparam int MAX_PRINTS    = 20;

   // Scoreboard: node grid predictor plus queue of expected results
   class node_scoreboard;
      logic signed [COST_W-1:0] cost_mem [NODES];
      bit                       bit_mem  [NODES];
      int                       largest;
      int                       total;
      result_type               expected_q [$];
      int                       errors;
      int                       checked;
      int                       sets;
      int                       clears;

      function new();
         foreach (bit_mem[i]) begin
            bit_mem[i]  = 1'b0;
            cost_mem[i] = '0;
         end
         largest = LARGEST_RESET;
         total   = 0;
         errors  = 0;
         checked = 0;
         sets    = 0;
         clears  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Accepted request word: advance the grid and queue its result
      function void note_word(item_type w);
         int         idx;
         int         r;
         int         c;
         int         cst;
         int         n;
         int         act;
         bit         prev;
         bit         now;
         result_type res;
         r    = w.row;
         c    = w.column;
         idx  = r * SIDE + c;
         prev = bit_mem[idx];
         act  = 0;
         if (w.operation == OP_LOAD) begin
            // reload drops the old cost of a set node from the total
            if (prev) total -= cost_mem[idx];
            cst           = w.cost;
            cost_mem[idx] = w.cost;
            now           = w.initial_state;
            if (now) total += cst;
            // largest cost only ever rises
            if (cst > largest) largest = cst;
         end else begin
            cst = cost_mem[idx];
            n   = 0;
            for (int k = 0; k < SIDE; k++) begin
               if (k != r) n += bit_mem[k * SIDE + c];
               if (k != c) n += bit_mem[r * SIDE + k];
            end
            act = 2 * largest - cst - 2 * largest * n;
            now = (act >= 0);
            if (now && !prev) begin
               total += cst;
               sets++;
            end else if (!now && prev) begin
               total -= cst;
               clears++;
            end
         end
         bit_mem[idx]       = now;
         res.previous_state = prev;
         res.node_state     = now;
         res.activation     = act[ACT_W-1:0];
         res.total_cost     = total[TOT_W-1:0];
         expected_q.push_back(res);
      endfunction

      task report_mismatch(string what, logic signed [31:0] want, logic signed [31:0] got);
         if (errors < MAX_PRINTS)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
         errors++;
      endtask

      // Accepted result word: compare with the oldest expectation
      task check_word(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result word", 0, got.total_cost);
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (got.previous_state !== want.previous_state)
               report_mismatch("previous_state", want.previous_state, got.previous_state);
            if (got.node_state !== want.node_state)
               report_mismatch("node_state", want.node_state, got.node_state);
            if (got.activation !== want.activation)
               report_mismatch("activation", want.activation, got.activation);
            if (got.total_cost !== want.total_cost)
               report_mismatch("total_cost", want.total_cost, got.total_cost);
         end
      endtask
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   node_scoreboard sb;
   int             send_idle_pct  = 0;
   int             rsp_stall_pct  = 0;
   int             hold_left      = 0;
   int             quiet_cycles   = 0;
   int             load_count     = 0;
   int             update_count   = 0;

   hopfield_assignment_node_update_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic item_type make_word(op_type op, int r, int c, int cost, bit init);
      item_type w;
      w.operation     = op;
      w.row           = r[IDX_W-1:0];
      w.column        = c[IDX_W-1:0];
      w.cost          = cost[COST_W-1:0];
      w.initial_state = init;
      return w;
   endfunction

   // Random word; every node is loaded by then, so any update is legal
   function automatic item_type random_word();
      int cost;
      if ($urandom_range(3) == 0) cost = $signed($urandom_range(16'hFFFF) - 32768);
      else                        cost = $urandom_range(4095) - 2048;
      return make_word(($urandom_range(99) < 40) ? OP_LOAD : OP_UPDATE,
                       $urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                       cost, $urandom_range(1));
   endfunction

   // Offer one word, with idle cycles first, and wait for acceptance
   task send_word(item_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.operation;
      req_tdata  <= {3'b000, w.initial_state, w.cost, w.column, w.row};
      do @(posedge clock); while (!req_tready);
      sb.note_word(w);
      if (w.operation == OP_LOAD) load_count++;
      else                        update_count++;
   endtask

   // Stop offering and wait until every expected result is back
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Result side: check accepted words, then pick next tready
   always @(posedge clock) begin : rsp_side
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.previous_state = rsp_tdata[0];
         got.node_state     = rsp_tdata[1];
         got.activation     = rsp_tdata[24:2];
         got.total_cost     = rsp_tdata[48:25];
         sb.check_word(got);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog on cycles where neither stream moves a word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : main
      int k;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, largest-cost floor, reload of a set node
      send_word(make_word(OP_LOAD,   0, 0, -32768, 1'b1));
      send_word(make_word(OP_LOAD,   0, 1, -1600,  1'b0));  // equals floor, no raise
      send_word(make_word(OP_UPDATE, 0, 0, 0,      1'b0));
      send_word(make_word(OP_UPDATE, 0, 1, 0,      1'b0));
      send_word(make_word(OP_LOAD,   0, 0, 100,    1'b0));  // reload of a set node
      send_word(make_word(OP_LOAD,   1, 1, -16,    1'b1));
      send_word(make_word(OP_UPDATE, 1, 1, 0,      1'b0));
      send_word(make_word(OP_LOAD,   0, 1, 0,      1'b1));  // reload, new bit set
      k = 0;
      for (int idx = 0; idx < NODES; idx++) begin
         if (idx == 0 || idx == 1 || idx == 5) continue;
         if (idx == NODES - 1)
            send_word(make_word(OP_LOAD, idx / SIDE, idx % SIDE, 32767, 1'b1));
         else
            send_word(make_word(OP_LOAD, idx / SIDE, idx % SIDE,
                                k[0] ? -(k * 211) : k * 173, k[0]));
         k++;
      end
      send_word(make_word(OP_UPDATE, 3, 3, 0, 1'b0));
      send_word(make_word(OP_UPDATE, 2, 2, 0, 1'b0));
      send_word(make_word(OP_UPDATE, 0, 0, 0, 1'b0));
      drain();

      // Random: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // long receiver hold-off while words keep coming
            if (phase == 0 && i == 10) hold_left = HOLD_CYCLES;
            send_word(random_word());
         end
         drain();
      end

      rsp_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d updates over four idling phases, %0d results checked",
               load_count, update_count, sb.checked);
      $display("updates set %0d node bits and cleared %0d; %0d mismatches",
               sb.sets, sb.clears, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hanu_pkg.sv
rtl/hanu_state.sv
rtl/hanu_eval.sv
rtl/hopfield_assignment_node_update_unit.sv
rtl/hanu_checker.sv
tb/sv/testbench.sv
